FILE: rtl/bsonp_pkg.sv
// ----------------------------------------------------------------------------
// bsonp_pkg
// Types, codes and constants shared by the parser's modules.
// ----------------------------------------------------------------------------
package bsonp_pkg;

  // Default bound on a name, terminator included.
  localparam int NAME_LIMIT = 32;

  // Element type codes.
  localparam logic [7:0] T_EOO    = 8'h00;
  localparam logic [7:0] T_DOUBLE = 8'h01;
  localparam logic [7:0] T_STRING = 8'h02;
  localparam logic [7:0] T_BINARY = 8'h05;
  localparam logic [7:0] T_INT    = 8'h10;

  // The name terminator.
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // Event kinds.
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_ELEMENT = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Error codes.
  localparam logic ERR_NAME_LONG = 1'b0;
  localparam logic ERR_BAD_TYPE  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_document;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  element_type;
    logic [7:0]  byte_value;
    logic [31:0] int_value;
    logic [63:0] double_bits;
    logic [30:0] payload_length;
    logic [7:0]  binary_subtype;
    logic        last_payload;
    logic        error_code;
  } result_t;

endpackage

FILE: rtl/bsonp_in_stage.sv
// ----------------------------------------------------------------------------
// bsonp_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module bsonp_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsonp_pkg::item_t in_item,
  input  logic             advance,
  output logic             item_valid,
  output bsonp_pkg::item_t item
);

  logic             valid_r;
  logic             valid_nxt;
  bsonp_pkg::item_t item_r;

  // The register frees up in the same cycle as its content is consumed.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_ready ? valid_nxt : valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/bsonp_core.sv
// ----------------------------------------------------------------------------
// bsonp_core
// Phase machine of the parser: one byte per step, at most one result.
// ----------------------------------------------------------------------------
module bsonp_core #(
  parameter int NAME_LIMIT = bsonp_pkg::NAME_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  bsonp_pkg::item_t   item,
  input  logic               deliver_payload,
  output logic               res_valid,
  output bsonp_pkg::result_t res
);

  localparam int NC_W = $clog2(NAME_LIMIT);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LENGTH,
    PH_TYPE,
    PH_NAME,
    PH_VALUE,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [NC_W-1:0] name_count_r, name_count_nxt;
  logic [7:0]  current_type_r, current_type_nxt;
  logic [63:0] value_shift_r, value_shift_nxt;
  logic [30:0] payload_remaining_r, payload_remaining_nxt;
  logic [7:0]  subtype_hold_r, subtype_hold_nxt;

  logic [7:0]  b;
  logic [3:0]  bc_inc;
  logic [3:0]  value_len;
  logic [63:0] shift_in;
  logic [31:0] raw_len;
  logic [30:0] len_clip;
  logic        known_type;

  assign b      = item.data_byte;
  assign bc_inc = byte_count_r + 4'd1;

  // Bytes carried by the value field of each type, length words included.
  always_comb begin
    priority if (current_type_r == bsonp_pkg::T_INT ||
                 current_type_r == bsonp_pkg::T_STRING) begin
      value_len = 4'd4;
    end else if (current_type_r == bsonp_pkg::T_BINARY) begin
      value_len = 4'd5;
    end else begin
      value_len = 4'd8;
    end
  end

  assign known_type = (current_type_r == bsonp_pkg::T_INT)    ||
                      (current_type_r == bsonp_pkg::T_DOUBLE) ||
                      (current_type_r == bsonp_pkg::T_STRING) ||
                      (current_type_r == bsonp_pkg::T_BINARY);

  // Little-endian assembly: the byte lands in the lane that the count selects.
  always_comb begin
    shift_in = value_shift_r;
    for (int i = 0; i < 8; i++) begin
      if (byte_count_r == 4'(i)) begin
        shift_in[8*i +: 8] = value_shift_r[8*i +: 8] | b;
      end
    end
  end

  assign raw_len  = shift_in[31:0];
  assign len_clip = raw_len[31] ? 31'd0 : raw_len[30:0];

  always_comb begin
    phase_nxt             = phase_r;
    byte_count_nxt        = byte_count_r;
    name_count_nxt        = name_count_r;
    current_type_nxt      = current_type_r;
    value_shift_nxt       = value_shift_r;
    payload_remaining_nxt = payload_remaining_r;
    subtype_hold_nxt      = subtype_hold_r;
    res_valid             = 1'b0;
    res                   = '0;

    if (item.start_document) begin
      phase_nxt      = PH_LENGTH;
      byte_count_nxt = 4'd1;
    end else begin
      unique case (phase_r)
        PH_LENGTH: begin
          byte_count_nxt = bc_inc;
          if (bc_inc >= 4'd4) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          current_type_nxt = b;
          if (b == bsonp_pkg::T_EOO) begin
            phase_nxt      = PH_IDLE;
            res_valid      = 1'b1;
            res.event_kind = bsonp_pkg::KIND_END;
          end else begin
            name_count_nxt = '0;
            phase_nxt      = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b == bsonp_pkg::NUL_BYTE) begin
            if (known_type) begin
              phase_nxt       = PH_VALUE;
              byte_count_nxt  = 4'd0;
              value_shift_nxt = '0;
            end else begin
              phase_nxt        = PH_IDLE;
              res_valid        = 1'b1;
              res.event_kind   = bsonp_pkg::KIND_ERROR;
              res.element_type = current_type_r;
              res.error_code   = bsonp_pkg::ERR_BAD_TYPE;
            end
          end else if (name_count_r == NC_W'(NAME_LIMIT - 1)) begin
            // No room is left for the terminator.
            phase_nxt        = PH_IDLE;
            res_valid        = 1'b1;
            res.event_kind   = bsonp_pkg::KIND_ERROR;
            res.element_type = current_type_r;
            res.error_code   = bsonp_pkg::ERR_NAME_LONG;
          end else begin
            name_count_nxt   = name_count_r + 1'b1;
            res_valid        = 1'b1;
            res.event_kind   = bsonp_pkg::KIND_NAME;
            res.element_type = current_type_r;
            res.byte_value   = b;
          end
        end
        PH_VALUE: begin
          value_shift_nxt = (byte_count_r < 4'd8) ? shift_in : value_shift_r;
          if (current_type_r == bsonp_pkg::T_BINARY && byte_count_r == 4'd4) begin
            subtype_hold_nxt = b;
          end
          byte_count_nxt = bc_inc;
          if (bc_inc >= value_len) begin
            res_valid        = 1'b1;
            res.event_kind   = bsonp_pkg::KIND_ELEMENT;
            res.element_type = current_type_r;
            if (current_type_r == bsonp_pkg::T_INT) begin
              res.int_value = value_shift_nxt[31:0];
              phase_nxt     = PH_TYPE;
            end else if (current_type_r == bsonp_pkg::T_DOUBLE) begin
              res.double_bits = value_shift_nxt;
              phase_nxt       = PH_TYPE;
            end else begin
              payload_remaining_nxt = len_clip;
              if (current_type_r != bsonp_pkg::T_BINARY) begin
                subtype_hold_nxt = 8'd0;
              end
              res.payload_length = len_clip;
              res.binary_subtype = subtype_hold_nxt;
              phase_nxt          = (len_clip != 31'd0) ? PH_PAYLOAD : PH_TYPE;
            end
          end
        end
        PH_PAYLOAD: begin
          if (payload_remaining_r != 31'd0) begin
            payload_remaining_nxt = payload_remaining_r - 31'd1;
          end
          if (payload_remaining_nxt == 31'd0) begin
            phase_nxt = PH_TYPE;
          end
          if (deliver_payload) begin
            res_valid          = 1'b1;
            res.event_kind     = bsonp_pkg::KIND_PAYLOAD;
            res.element_type   = current_type_r;
            res.byte_value     = b;
            res.binary_subtype = (current_type_r == bsonp_pkg::T_BINARY) ?
                                 subtype_hold_r : 8'd0;
            res.last_payload   = (payload_remaining_nxt == 31'd0);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= PH_IDLE;
      byte_count_r        <= '0;
      name_count_r        <= '0;
      current_type_r      <= '0;
      value_shift_r       <= '0;
      payload_remaining_r <= '0;
      subtype_hold_r      <= '0;
    end else if (step) begin
      phase_r             <= phase_nxt;
      byte_count_r        <= byte_count_nxt;
      name_count_r        <= name_count_nxt;
      current_type_r      <= current_type_nxt;
      value_shift_r       <= value_shift_nxt;
      payload_remaining_r <= payload_remaining_nxt;
      subtype_hold_r      <= subtype_hold_nxt;
    end
  end

endmodule

FILE: rtl/bsonp_out_reg.sv
// ----------------------------------------------------------------------------
// bsonp_out_reg
// Result register that holds one event until the consumer takes it.
// ----------------------------------------------------------------------------
module bsonp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               res_valid,
  input  bsonp_pkg::result_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output bsonp_pkg::result_t out_res
);

  logic               valid_r;
  bsonp_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/bson_element_parser.sv
// ----------------------------------------------------------------------------
// bson_element_parser
// Path: a byte is taken into the input register at its transfer; its event
//   enters the result register when the byte advances, which a stall can delay.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset: synchronous, active low; the parser goes idle, payload delivery is
//   switched off and both pipeline registers are emptied.
// ----------------------------------------------------------------------------
module bson_element_parser #(
  parameter int NAME_LIMIT = bsonp_pkg::NAME_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_document,
  // Events.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_element_type,
  output logic [7:0]  out_byte_value,
  output logic signed [31:0] out_int_value,
  output logic [63:0] out_double_bits,
  output logic [30:0] out_payload_length,
  output logic [7:0]  out_binary_subtype,
  output logic        out_last_payload,
  output logic        out_error_code,
  // Configuration.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_deliver_payload
);

  bsonp_pkg::item_t   in_item;
  bsonp_pkg::item_t   item;
  bsonp_pkg::result_t res;
  bsonp_pkg::result_t out_res;
  logic               item_valid;
  logic               advance;
  logic               res_valid;
  logic               deliver_payload_r;

  // The configuration register takes a write in any cycle; the user must make
  // writes only while the stream is quiet (unchecked): no value changes mid-step.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_payload_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      deliver_payload_r <= cfg_deliver_payload;
    end
  end

  assign in_item.data_byte      = in_data_byte;
  assign in_item.start_document = in_start_document;

  // A held byte moves through the phase machine whenever the result register
  // is empty or being drained in this cycle. Bytes that cause no event still
  // advance, leaving the result register empty behind them.
  assign advance = item_valid && (!out_valid || out_ready);

  bsonp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bsonp_core #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .item            (item),
    .deliver_payload (deliver_payload_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  bsonp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_event_kind     = out_res.event_kind;
  assign out_element_type   = out_res.element_type;
  assign out_byte_value     = out_res.byte_value;
  assign out_int_value      = out_res.int_value;
  assign out_double_bits    = out_res.double_bits;
  assign out_payload_length = out_res.payload_length;
  assign out_binary_subtype = out_res.binary_subtype;
  assign out_last_payload   = out_res.last_payload;
  assign out_error_code     = out_res.error_code;

  // Input back-pressure only ever comes from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // Only an element-ready event carries assembled value fields.
  a_value_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != bsonp_pkg::KIND_ELEMENT) |->
    (out_int_value == 32'sd0 && out_double_bits == 64'd0 &&
     out_payload_length == 31'd0))
    else $error("value fields set outside an element-ready event");

  // The last-byte flag belongs to payload transfers only.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_payload) |-> (out_event_kind == bsonp_pkg::KIND_PAYLOAD))
    else $error("last-payload flag on a non-payload event");

  // A payload event is only produced while delivery is switched on.
  a_payload_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.event_kind == bsonp_pkg::KIND_PAYLOAD) |->
    deliver_payload_r)
    else $error("payload event while delivery is off");

endmodule

FILE: sim/bson_element_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bson_element_parser_tb
// Self-checking bench for the byte-serial BSON element parser. Documents are
// built from typed elements, with directed corner cases first and random
// documents after them. Every byte transfer is run through a software copy of
// the phase machine, and each event transfer is checked against the oldest
// event that copy is still waiting for.
// ----------------------------------------------------------------------------
module bson_element_parser_tb;

  localparam int RANDOM_BYTES   = 1500;
  localparam int QUIET_BYTES    = 150;   // final stretch without any idling
  localparam int LATENCY        = 2;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LENGTH, PH_TYPE, PH_NAME, PH_VALUE, PH_PAYLOAD
  } parse_phase_t;

  // Mirrors the parser's phase machine and holds the events it predicts.
  class bson_event_scoreboard;
    parse_phase_t        phase     = PH_IDLE;
    int                  byte_cnt  = 0;
    int                  name_cnt  = 0;
    logic [7:0]          cur_type  = '0;
    logic [63:0]         value_acc = '0;
    logic [30:0]         remaining = '0;
    logic [7:0]          subtype   = '0;
    bit                  deliver   = 1'b0;
    bsonp_pkg::result_t  awaited_events[$];
    int                  failures  = 0;
    int                  kind_count[5];

    function int pending();
      return awaited_events.size();
    endfunction

    // Returns 1 unless the byte was ignored by an idle parser.
    function bit note_byte(logic [7:0] b, logic start);
      bsonp_pkg::result_t ev;
      logic [31:0]        raw;
      int                 need;
      ev = '0;
      if (start) begin
        phase    = PH_LENGTH;
        byte_cnt = 1;
        return 1'b1;
      end
      case (phase)
        PH_LENGTH: begin
          byte_cnt++;
          if (byte_cnt >= 4) phase = PH_TYPE;
        end
        PH_TYPE: begin
          cur_type = b;
          if (b == bsonp_pkg::T_EOO) begin
            phase         = PH_IDLE;
            ev.event_kind = bsonp_pkg::KIND_END;
            awaited_events.push_back(ev);
          end else begin
            name_cnt = 0;
            phase    = PH_NAME;
          end
        end
        PH_NAME: begin
          ev.element_type = cur_type;
          if (b == bsonp_pkg::NUL_BYTE) begin
            if (cur_type == bsonp_pkg::T_INT || cur_type == bsonp_pkg::T_DOUBLE ||
                cur_type == bsonp_pkg::T_STRING || cur_type == bsonp_pkg::T_BINARY) begin
              phase     = PH_VALUE;
              byte_cnt  = 0;
              value_acc = '0;
            end else begin
              phase         = PH_IDLE;
              ev.event_kind = bsonp_pkg::KIND_ERROR;
              ev.error_code = bsonp_pkg::ERR_BAD_TYPE;
              awaited_events.push_back(ev);
            end
          end else if (name_cnt + 1 >= bsonp_pkg::NAME_LIMIT) begin
            phase         = PH_IDLE;
            ev.event_kind = bsonp_pkg::KIND_ERROR;
            ev.error_code = bsonp_pkg::ERR_NAME_LONG;
            awaited_events.push_back(ev);
          end else begin
            name_cnt++;
            ev.event_kind = bsonp_pkg::KIND_NAME;
            ev.byte_value = b;
            awaited_events.push_back(ev);
          end
        end
        PH_VALUE: begin
          if (byte_cnt < 8) value_acc |= 64'(b) << (8 * byte_cnt);
          if (cur_type == bsonp_pkg::T_BINARY && byte_cnt == 4) subtype = b;
          byte_cnt++;
          need = (cur_type == bsonp_pkg::T_BINARY) ? 5 :
                 (cur_type == bsonp_pkg::T_INT || cur_type == bsonp_pkg::T_STRING) ? 4 : 8;
          if (byte_cnt >= need) begin
            ev.event_kind   = bsonp_pkg::KIND_ELEMENT;
            ev.element_type = cur_type;
            if (cur_type == bsonp_pkg::T_INT) begin
              ev.int_value = value_acc[31:0];
              phase        = PH_TYPE;
            end else if (cur_type == bsonp_pkg::T_DOUBLE) begin
              ev.double_bits = value_acc;
              phase          = PH_TYPE;
            end else begin
              // A negative length means there is no payload at all.
              raw       = value_acc[31:0];
              remaining = raw[31] ? '0 : raw[30:0];
              if (cur_type != bsonp_pkg::T_BINARY) subtype = '0;
              ev.payload_length = remaining;
              ev.binary_subtype = subtype;
              phase = (remaining != 0) ? PH_PAYLOAD : PH_TYPE;
            end
            awaited_events.push_back(ev);
          end
        end
        PH_PAYLOAD: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) phase = PH_TYPE;
          if (deliver) begin
            ev.event_kind     = bsonp_pkg::KIND_PAYLOAD;
            ev.element_type   = cur_type;
            ev.byte_value     = b;
            ev.binary_subtype = (cur_type == bsonp_pkg::T_BINARY) ? subtype : '0;
            ev.last_payload   = (remaining == 0);
            awaited_events.push_back(ev);
          end
        end
        default: begin
          phase = PH_IDLE;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    function bit field_ok(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_event(bsonp_pkg::result_t got);
      bsonp_pkg::result_t want;
      bit                 ok;
      if (awaited_events.size() == 0) begin
        $display("%0t: event kind %0d arrived with none expected, expected none, actual %0h",
                 $time, got.event_kind, got);
        failures++;
        return;
      end
      want = awaited_events.pop_front();
      ok = 1'b1;
      ok &= field_ok("event_kind", want.event_kind, got.event_kind);
      ok &= field_ok("element_type", want.element_type, got.element_type);
      ok &= field_ok("byte_value", want.byte_value, got.byte_value);
      ok &= field_ok("int_value", want.int_value, got.int_value);
      ok &= field_ok("double_bits", want.double_bits, got.double_bits);
      ok &= field_ok("payload_length", want.payload_length, got.payload_length);
      ok &= field_ok("binary_subtype", want.binary_subtype, got.binary_subtype);
      ok &= field_ok("last_payload", want.last_payload, got.last_payload);
      ok &= field_ok("error_code", want.error_code, got.error_code);
      if (!ok) failures++;
      if (want.event_kind < 5) kind_count[want.event_kind]++;
    endfunction
  endclass

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte        = '0;
  logic        in_start_document   = 1'b0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_element_type;
  logic [7:0]  out_byte_value;
  logic signed [31:0] out_int_value;
  logic [63:0] out_double_bits;
  logic [30:0] out_payload_length;
  logic [7:0]  out_binary_subtype;
  logic        out_last_payload;
  logic        out_error_code;
  logic        cfg_valid           = 1'b0;
  logic        cfg_ready;
  logic        cfg_deliver_payload = 1'b0;

  bson_event_scoreboard event_board;

  int bytes_in      = 0;  // every byte transfer
  int parsed_bytes  = 0;  // byte transfers that the parser did not ignore
  int cfg_writes    = 0;
  int stall_cycles  = 0;
  int calm_left     = 0;
  int hold_offs     = 0;
  bit quiet         = 1'b0;
  bit hold_off_req  = 1'b0;

  bson_element_parser u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_start_document   (in_start_document),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_kind      (out_event_kind),
    .out_element_type    (out_element_type),
    .out_byte_value      (out_byte_value),
    .out_int_value       (out_int_value),
    .out_double_bits     (out_double_bits),
    .out_payload_length  (out_payload_length),
    .out_binary_subtype  (out_binary_subtype),
    .out_last_payload    (out_last_payload),
    .out_error_code      (out_error_code),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_deliver_payload (cfg_deliver_payload)
  );

  always #6 clk = ~clk;

  // All sampling happens at the rising edge, before the nonblocking updates
  // of that edge land, so the bench sees the same values the parser does.
  always @(posedge clk) begin : transfer_monitor
    bsonp_pkg::result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_event_kind, out_element_type, out_byte_value, out_int_value,
               out_double_bits, out_payload_length, out_binary_subtype,
               out_last_payload, out_error_code};
        event_board.check_event(got);
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        if (event_board.note_byte(in_data_byte, in_start_document)) parsed_bytes++;
      end
      if (cfg_valid && cfg_ready) begin
        event_board.deliver = cfg_deliver_payload;
        cfg_writes++;
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d events still awaited",
               $time, stall_cycles, event_board.pending());
      $display("bson_element_parser: mismatch");
      $finish;
    end
  end

  // The event receiver. It stalls in short random bursts, sometimes runs
  // freely for a while, and once holds off for a long stretch so that both
  // pipeline registers fill and the parser has to stop taking bytes.
  initial begin : event_sink
    int span;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_offs++;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : 1;
        out_ready <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offers one byte and returns at the edge of its transfer. Valid stays
  // high from one byte to the next unless an idle burst is inserted.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (calm_left > 0) begin
      calm_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else if ($urandom_range(0, 31) == 0) begin
      calm_left = $urandom_range(20, 80);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_start_document <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Start flag plus three length bytes; the length itself is discarded.
  task automatic send_header();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_byte(v[8*i +: 8], 1'b0);
  endtask

  // Type byte, a name of name_len non-NUL characters and its terminator,
  // then the value field for the known types. For string and binary the
  // low word of v is the raw length; for binary bits 39:32 are the subtype.
  // pay_n payload bytes follow.
  task automatic send_element(input logic [7:0] etype, input int name_len,
                              input logic [63:0] v, input int pay_n);
    send_byte(etype, 1'b0);
    for (int i = 0; i < name_len; i++) send_byte(8'($urandom_range(1, 255)), 1'b0);
    send_byte(bsonp_pkg::NUL_BYTE, 1'b0);
    case (etype)
      bsonp_pkg::T_INT, bsonp_pkg::T_STRING: send_le(v, 4);
      bsonp_pkg::T_DOUBLE:                   send_le(v, 8);
      bsonp_pkg::T_BINARY:                   send_le(v, 5);
      default:                               ;
    endcase
    for (int i = 0; i < pay_n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Waits until every predicted event has been taken, then lets any skipped
  // payload byte still in flight, which makes no event, drain out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (event_board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input bit deliver);
    settle();
    cfg_valid           <= 1'b1;
    cfg_deliver_payload <= deliver;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          rnd_base;
    int          n_elem;
    int          pick;
    int          nlen;
    int          pay;
    int          docs;
    bit          broke;
    logic [31:0] len_raw;
    logic [63:0] v;

    event_board = new;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Payload delivery is off after reset, so the first
    // string's payload is skipped without events.
    send_byte(8'h00, 1'b0);                 // bytes while idle are ignored
    send_byte(8'hFF, 1'b0);
    send_header();
    send_element(bsonp_pkg::T_INT, 1, 64'h8000_0000, 0);
    send_element(bsonp_pkg::T_STRING, 0, 64'd2, 2);
    send_byte(bsonp_pkg::T_EOO, 1'b0);

    write_cfg(1'b1);
    send_header();
    send_element(bsonp_pkg::T_INT, 0, 64'h7FFF_FFFF, 0);
    send_element(bsonp_pkg::T_DOUBLE, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_element(bsonp_pkg::T_STRING, 1, 64'd1, 1);
    send_element(bsonp_pkg::T_BINARY, 0, {24'h0, 8'hFF, 32'd2}, 2);
    send_element(bsonp_pkg::T_STRING, 0, 64'hFFFF_FFFF, 0);  // negative length
    send_element(bsonp_pkg::T_BINARY, 0, 64'd0, 0);          // zero length
    send_byte(bsonp_pkg::T_EOO, 1'b0);

    // Unsupported type: the name comes out first, the NUL raises the error.
    send_header();
    send_element(8'h07, 1, 64'd0, 0);

    // Longest legal name, then one character too many.
    send_header();
    send_element(bsonp_pkg::T_INT, bsonp_pkg::NAME_LIMIT - 1, 64'h0, 0);
    send_element(bsonp_pkg::T_INT, bsonp_pkg::NAME_LIMIT, 64'h0, 0);

    // A start flag in the middle of a name abandons the element quietly.
    send_header();
    send_byte(bsonp_pkg::T_INT, 1'b0);
    send_byte(8'h41, 1'b0);
    send_header();
    send_byte(bsonp_pkg::T_EOO, 1'b0);

    // Delivery switched off part way through a payload and back on after it.
    send_header();
    send_element(bsonp_pkg::T_STRING, 0, 64'd4, 2);
    write_cfg(1'b0);
    send_le({$urandom, $urandom}, 2);
    write_cfg(1'b1);
    send_byte(bsonp_pkg::T_EOO, 1'b0);

    // Random part. Most documents are well formed with random content; a
    // minority carry bad types, long names, restarts and idle noise.
    rnd_base = parsed_bytes;
    docs     = 0;
    while (parsed_bytes - rnd_base < RANDOM_BYTES) begin
      if (parsed_bytes - rnd_base >= RANDOM_BYTES - QUIET_BYTES) quiet = 1'b1;
      if (hold_offs == 0 && !hold_off_req && parsed_bytes - rnd_base > 600)
        hold_off_req = 1'b1;
      if (docs % 10 == 9 && !quiet) write_cfg(1'($urandom_range(0, 1)));
      docs++;

      if ($urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);

      send_header();
      n_elem = $urandom_range(0, 6);
      broke  = 1'b0;
      for (int e = 0; e < n_elem && !broke; e++) begin
        pick = $urandom_range(0, 99);
        nlen = ($urandom_range(0, 15) == 0) ? bsonp_pkg::NAME_LIMIT - 1 :
                                              $urandom_range(0, 6);
        v    = {$urandom, $urandom};
        case ($urandom_range(0, 9))
          0:       len_raw = {1'b1, 31'($urandom)};
          1:       len_raw = 32'd0;
          default: len_raw = $urandom_range(1, 10);
        endcase
        pay = len_raw[31] ? 0 : int'(len_raw);
        if (pick < 25) begin
          send_element(bsonp_pkg::T_INT, nlen, v, 0);
        end else if (pick < 45) begin
          send_element(bsonp_pkg::T_DOUBLE, nlen, v, 0);
        end else if (pick < 65) begin
          send_element(bsonp_pkg::T_STRING, nlen, {32'h0, len_raw}, pay);
        end else if (pick < 85) begin
          send_element(bsonp_pkg::T_BINARY, nlen, {v[63:32], len_raw}, pay);
        end else if (pick < 90) begin
          do v[7:0] = 8'($urandom_range(1, 255));
          while (v[7:0] == bsonp_pkg::T_INT || v[7:0] == bsonp_pkg::T_DOUBLE ||
                 v[7:0] == bsonp_pkg::T_STRING || v[7:0] == bsonp_pkg::T_BINARY);
          send_element(v[7:0], nlen, 64'h0, 0);
          broke = 1'b1;
        end else if (pick < 94) begin
          send_element(bsonp_pkg::T_INT, bsonp_pkg::NAME_LIMIT + $urandom_range(0, 8), v, 0);
          broke = 1'b1;
        end else if (pick < 97) begin
          // Huge length, cut short by the next document's start flag.
          len_raw = {2'b01, 30'($urandom)};
          send_element(($urandom_range(0, 1) != 0) ? bsonp_pkg::T_STRING :
                                                     bsonp_pkg::T_BINARY, nlen,
                       {v[63:32], len_raw}, $urandom_range(1, 3));
          broke = 1'b1;
        end else begin
          send_byte(8'($urandom_range(1, 255)), 1'b0);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)), 1'b0);
          broke = 1'b1;
        end
      end
      if (!broke && $urandom_range(0, 9) != 0) send_byte(bsonp_pkg::T_EOO, 1'b0);
    end

    // Drain: nothing left to send, wait for the last events to come out.
    quiet = 1'b1;
    settle();
    repeat (4 * LATENCY) @(posedge clk);

    $display("%0d byte transfers (%0d parsed), %0d configuration writes, %0d long hold-offs",
             bytes_in, parsed_bytes, cfg_writes, hold_offs);
    $display("events checked: name %0d, element %0d, payload %0d, end %0d, error %0d",
             event_board.kind_count[bsonp_pkg::KIND_NAME],
             event_board.kind_count[bsonp_pkg::KIND_ELEMENT],
             event_board.kind_count[bsonp_pkg::KIND_PAYLOAD],
             event_board.kind_count[bsonp_pkg::KIND_END],
             event_board.kind_count[bsonp_pkg::KIND_ERROR]);
    if (event_board.pending() != 0)
      $display("%0t: %0d events expected, actual 0 arrived", $time, event_board.pending());
    if (event_board.failures == 0 && event_board.pending() == 0)
      $display("bson_element_parser: match");
    else
      $display("bson_element_parser: mismatch");
    $finish;
  end

endmodule
